[hdl/dpb_pkg.sv]
// dpb_pkg: shared constants, register codes and width helpers for the
// depth to point backprojection block. No dependencies.
`default_nettype none

package dpb_pkg;

  // field widths
  localparam int DEPTH_W     = 16;
  localparam int CENTER_W    = 16;
  localparam int CENTER_FRAC = 4;
  localparam int INV_W       = 24;
  localparam int DIM_W       = 13;
  localparam int POINT_W     = 37;
  localparam int FRAC_SHIFT  = 20;

  // configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

  // register reset values
  localparam logic [CENTER_W-1:0] CENTER_X_RST    = 16'd4775;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST    = 16'd3960;
  localparam logic [INV_W-1:0]    INV_FOCAL_X_RST = 24'd27272;
  localparam logic [INV_W-1:0]    INV_FOCAL_Y_RST = 24'd27272;
  localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST = 13'd640;
  localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 13'd480;

  // defaults for top level parameters
  localparam int MAX_DIM_DEF    = 4096;
  localparam int FIFO_DEPTH_DEF = 4;

  // bits needed to hold a position plus one, up to max_dim
  function automatic int pos_width(input int max_dim);
    return $clog2(max_dim + 1);
  endfunction

  // signed width of the offset ((pos+1) << 4) - center
  function automatic int off_width(input int max_dim);
    int p;
    p = pos_width(max_dim) + CENTER_FRAC;
    return ((p > CENTER_W) ? p : CENTER_W) + 1;
  endfunction

endpackage

`default_nettype wire

[hdl/dpb_front.sv]
// dpb_front: accepts depth items, runs the raster counters and forms the
// signed pixel offsets and frame end flag. Depends on dpb_pkg.
`default_nettype none

module dpb_front
  import dpb_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [DEPTH_W-1:0]             depth_mm,
  input  logic [CENTER_W-1:0]            center_x,
  input  logic [CENTER_W-1:0]            center_y,
  input  logic [DIM_W-1:0]               frame_width,
  input  logic [DIM_W-1:0]               frame_height,
  output logic                           push_valid,
  input  logic                           push_ready,
  output logic [DEPTH_W-1:0]             push_depth,
  output logic [off_width(MAX_DIM)-1:0]  push_off_x,
  output logic [off_width(MAX_DIM)-1:0]  push_off_y,
  output logic                           push_last
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int POS_W = pos_width(MAX_DIM);
  localparam int OFF_W = off_width(MAX_DIM);
  localparam int CMP_W = (DIM_W > POS_W) ? DIM_W : POS_W;

  logic [CNT_W-1:0] column_count, column_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;
  logic [POS_W-1:0] col_inc, row_inc;
  logic [CMP_W-1:0] w_clamp, h_clamp;
  logic             row_end, last;
  logic             accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  // clamp frame size to 1..MAX_DIM
  always_comb begin
    w_clamp = CMP_W'(frame_width);
    if (w_clamp == '0) begin
      w_clamp = CMP_W'(1);
    end else if (w_clamp > CMP_W'(MAX_DIM)) begin
      w_clamp = CMP_W'(MAX_DIM);
    end
    h_clamp = CMP_W'(frame_height);
    if (h_clamp == '0) begin
      h_clamp = CMP_W'(1);
    end else if (h_clamp > CMP_W'(MAX_DIM)) begin
      h_clamp = CMP_W'(MAX_DIM);
    end
  end

  // row and frame end detection
  assign col_inc = POS_W'(column_count) + POS_W'(1);
  assign row_inc = POS_W'(row_count) + POS_W'(1);
  assign row_end = CMP_W'(col_inc) >= w_clamp;
  assign last    = row_end && (CMP_W'(row_inc) >= h_clamp);

  // counter next values
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (row_end) begin
      column_count_next = '0;
      row_count_next    = last ? '0 : CNT_W'(row_inc);
    end else begin
      column_count_next = CNT_W'(col_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // signed offsets with 4 fraction bits
  assign push_off_x = OFF_W'({col_inc, {CENTER_FRAC{1'b0}}}) - OFF_W'(center_x);
  assign push_off_y = OFF_W'({row_inc, {CENTER_FRAC{1'b0}}}) - OFF_W'(center_y);
  assign push_valid = in_valid;
  assign push_depth = depth_mm;
  assign push_last  = last;

endmodule

`default_nettype wire

[hdl/dpb_fifo.sv]
// dpb_fifo: short item queue between the front and back parts.
// Register array with head and tail pointers. Depends on dpb_pkg.
`default_nettype none

module dpb_fifo
  import dpb_pkg::*;
#(
  parameter int DATA_W = 8,
  parameter int DEPTH  = FIFO_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/dpb_back.sv]
// dpb_back: two stage multiply pipeline that scales offsets by depth and
// inverse focal length, with the output register. Depends on dpb_pkg.
`default_nettype none

module dpb_back
  import dpb_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  logic [DEPTH_W-1:0]             pop_depth,
  input  logic [off_width(MAX_DIM)-1:0]  pop_off_x,
  input  logic [off_width(MAX_DIM)-1:0]  pop_off_y,
  input  logic                           pop_last,
  input  logic [INV_W-1:0]               inv_focal_x,
  input  logic [INV_W-1:0]               inv_focal_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [POINT_W-1:0]             point_x,
  output logic [POINT_W-1:0]             point_y,
  output logic [DEPTH_W-1:0]             point_z,
  output logic                           point_valid,
  output logic                           frame_last
);

  localparam int OFF_W = off_width(MAX_DIM);
  localparam int DO_W  = OFF_W + DEPTH_W + 1;
  localparam int P2_W  = DO_W + INV_W + 1;

  logic                   s1_valid, s1_ready, s2_ready;
  logic signed [DO_W-1:0] s1_px, s1_py;
  logic [DEPTH_W-1:0]     s1_z;
  logic                   s1_pv, s1_last;
  logic signed [DO_W-1:0] mul1_x, mul1_y;
  logic signed [P2_W-1:0] mul2_x, mul2_y;

  // stall chain
  assign s2_ready  = !out_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign pop_ready = s1_ready;

  // stage one: depth times offset
  assign mul1_x = $signed({1'b0, pop_depth}) * $signed(pop_off_x);
  assign mul1_y = $signed({1'b0, pop_depth}) * $signed(pop_off_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && pop_valid) begin
      s1_px   <= mul1_x;
      s1_py   <= mul1_y;
      s1_z    <= pop_depth;
      s1_pv   <= pop_depth != '0;
      s1_last <= pop_last;
    end
  end

  // stage two: times inverse focal length, floor shift to 8 fraction bits
  assign mul2_x = s1_px * $signed({1'b0, inv_focal_x});
  assign mul2_y = s1_py * $signed({1'b0, inv_focal_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      point_x     <= mul2_x[FRAC_SHIFT +: POINT_W];
      point_y     <= mul2_y[FRAC_SHIFT +: POINT_W];
      point_z     <= s1_z;
      point_valid <= s1_pv;
      frame_last  <= s1_last;
    end
  end

endmodule

`default_nettype wire

[hdl/depth_to_point_backprojection.sv]
// depth_to_point_backprojection: pinhole backprojection of a raster depth stream.
// Data path: queue write, stage one multiply register, then the output register.
// Throughput: one item per cycle unless out_ready stalls the two multiply stages.
// Reset: synchronous, clears counters, queue and pipeline, loads register defaults.
// Depends on dpb_pkg, dpb_front, dpb_fifo, dpb_back.
`default_nettype none

module depth_to_point_backprojection
  import dpb_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DEPTH_W-1:0]   depth_mm,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [POINT_W-1:0]   point_x,
  output logic [POINT_W-1:0]   point_y,
  output logic [DEPTH_W-1:0]   point_z,
  output logic                 point_valid,
  output logic                 frame_last,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int OFF_W   = off_width(MAX_DIM);
  localparam int ENTRY_W = 1 + DEPTH_W + 2 * OFF_W;

  logic [CENTER_W-1:0] center_x, center_y;
  logic [INV_W-1:0]    inv_focal_x, inv_focal_y;
  logic [DIM_W-1:0]    frame_width, frame_height;

  logic               push_valid, push_ready;
  logic [DEPTH_W-1:0] push_depth;
  logic [OFF_W-1:0]   push_off_x, push_off_y;
  logic               push_last;
  logic [ENTRY_W-1:0] push_data, pop_data;
  logic               pop_valid, pop_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= CENTER_X_RST;
      center_y     <= CENTER_Y_RST;
      inv_focal_x  <= INV_FOCAL_X_RST;
      inv_focal_y  <= INV_FOCAL_Y_RST;
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CENTER_X:     center_x     <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:     center_y     <= cfg_data[CENTER_W-1:0];
        REG_INV_FOCAL_X:  inv_focal_x  <= cfg_data[INV_W-1:0];
        REG_INV_FOCAL_Y:  inv_focal_y  <= cfg_data[INV_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // front: counters and offsets
  dpb_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .depth_mm     (depth_mm),
    .center_x     (center_x),
    .center_y     (center_y),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_depth   (push_depth),
    .push_off_x   (push_off_x),
    .push_off_y   (push_off_y),
    .push_last    (push_last)
  );

  // item queue
  assign push_data = {push_last, push_depth, push_off_y, push_off_x};

  dpb_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: multiply pipeline and output register
  dpb_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_depth   (pop_data[2*OFF_W +: DEPTH_W]),
    .pop_off_x   (pop_data[0 +: OFF_W]),
    .pop_off_y   (pop_data[OFF_W +: OFF_W]),
    .pop_last    (pop_data[ENTRY_W-1]),
    .inv_focal_x (inv_focal_x),
    .inv_focal_y (inv_focal_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .point_valid (point_valid),
    .frame_last  (frame_last)
  );

endmodule

`default_nettype wire

[hdl/dpb_checker.sv]
// dpb_checker: port level assertions for depth_to_point_backprojection,
// attached by the bind at the end of this file. Depends on dpb_pkg.
`default_nettype none

module dpb_checker
  import dpb_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [POINT_W-1:0] point_x,
  input logic [POINT_W-1:0] point_y,
  input logic [DEPTH_W-1:0] point_z,
  input logic               point_valid,
  input logic               frame_last
);

  // reset empties the result side
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
      && $stable(point_z) && $stable(point_valid) && $stable(frame_last))
    else $error("stalled item changed");

  // an item without a measurement is all zero
  a_zero_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> point_x == '0 && point_y == '0 && point_z == '0)
    else $error("invalid point not zero");

  // a valid point carries a nonzero depth
  a_valid_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && point_valid |-> point_z != '0)
    else $error("valid point with zero depth");

endmodule

bind depth_to_point_backprojection dpb_checker u_dpb_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .point_x     (point_x),
  .point_y     (point_y),
  .point_z     (point_z),
  .point_valid (point_valid),
  .frame_last  (frame_last)
);

`default_nettype wire
